@@ src/rtp_l16_audio_packetizer_macros.svh @@
// Assertion macros for the RTP L16 packetizer checker.
// Needs nothing but a clock and an active-low reset in the using scope.
`ifndef RTP_L16_AUDIO_PACKETIZER_MACROS_SVH
`define RTP_L16_AUDIO_PACKETIZER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RTPL16_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RTPL16_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/rtpl16_pkg.sv @@
// Shared constants and types for the RTP L16 packetizer.
// Used by the queue, the front end and the byte serialiser; depends on nothing.
package rtpl16_pkg;

	localparam int SPP_W    = 10;
	localparam int PT_W     = 7;
	localparam int SEQ_W    = 16;
	localparam int TS_W     = 32;
	localparam int SSRC_W   = 32;
	localparam int WORD_W   = 32;
	localparam int SAMPLE_W = 16;
	localparam int SAMPLE_LSB = 11;
	localparam int SAMPLE_MSB = SAMPLE_LSB + SAMPLE_W - 1;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] CFG_SPP  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SSRC = 2'd2;

	localparam logic [SPP_W-1:0]  SPP_RESET  = 10'd240;
	localparam logic [PT_W-1:0]   PT_RESET   = 7'd11;
	localparam logic [SSRC_W-1:0] SSRC_RESET = 32'h1234_5678;

	localparam logic [7:0] RTP_V2_BYTE = 8'h80;

	// Byte positions within one queued item: header bytes first, then the sample.
	localparam int BYTE_IDX_W = 4;
	localparam logic [BYTE_IDX_W-1:0] BYTE_HDR_FIRST  = 4'd0;
	localparam logic [BYTE_IDX_W-1:0] BYTE_HDR_LAST   = 4'd11;
	localparam logic [BYTE_IDX_W-1:0] BYTE_SAMPLE_HI  = 4'd12;
	localparam logic [BYTE_IDX_W-1:0] BYTE_SAMPLE_LO  = 4'd13;
	localparam int HDR_W = 8 + 8 + SEQ_W + TS_W + SSRC_W;

	localparam int Q_DEPTH = 2;
	localparam int Q_AW    = $clog2(Q_DEPTH);

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                hdr;
		logic                last;
		logic [PT_W-1:0]     pt;
		logic [SEQ_W-1:0]    seq;
		logic [TS_W-1:0]     ts;
		logic [SSRC_W-1:0]   ssrc;
	} item_t;

	typedef struct packed {
		logic push;
		logic pop;
	} q_req_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

@@ src/rtpl16_queue.sv @@
// Short register queue that decouples the front end from the byte serialiser.
// Depends on rtpl16_pkg for the item type and depth.
module rtpl16_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  rtpl16_pkg::q_req_t req,
	input  rtpl16_pkg::item_t  wr_item,
	output rtpl16_pkg::q_stat_t stat,
	output rtpl16_pkg::item_t  rd_item
);

	rtpl16_pkg::item_t mem_q [rtpl16_pkg::Q_DEPTH];
	logic [rtpl16_pkg::Q_AW-1:0] wptr_q;
	logic [rtpl16_pkg::Q_AW-1:0] rptr_q;
	logic [rtpl16_pkg::Q_AW:0]   count_q;
	logic do_push;
	logic do_pop;

	assign stat.full  = (count_q == (rtpl16_pkg::Q_AW+1)'(rtpl16_pkg::Q_DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = req.push && !stat.full;
	assign do_pop     = req.pop && !stat.empty;
	assign rd_item    = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ src/rtpl16_front.sv @@
// Front end: takes microphone words, keeps the packet state and the registers,
// and queues one classified item per word. Depends on rtpl16_pkg.
module rtpl16_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [rtpl16_pkg::WORD_W-1:0]         s_axis_tdata,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [rtpl16_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rtpl16_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  rtpl16_pkg::q_stat_t                   q_stat,
	output logic                                  q_push,
	output rtpl16_pkg::item_t                     q_item
);

	logic [rtpl16_pkg::SPP_W-1:0]  spp_q;
	logic [rtpl16_pkg::PT_W-1:0]   pt_q;
	logic [rtpl16_pkg::SSRC_W-1:0] ssrc_q;
	logic [rtpl16_pkg::SEQ_W-1:0]  seq_q;
	logic [rtpl16_pkg::TS_W-1:0]   ts_q;
	logic [rtpl16_pkg::SPP_W-1:0]  pos_q;

	logic [rtpl16_pkg::SPP_W-1:0] len;
	logic accept;
	logic first;
	logic last;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !q_stat.full;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// A length of zero behaves as a length of one.
	assign len   = (spp_q == '0) ? rtpl16_pkg::SPP_W'(1) : spp_q;
	assign first = (pos_q == '0);
	assign last  = (({1'b0, pos_q} + 1'b1) >= {1'b0, len});

	assign q_push        = accept;
	assign q_item.sample = s_axis_tdata[rtpl16_pkg::SAMPLE_MSB:rtpl16_pkg::SAMPLE_LSB];
	assign q_item.hdr    = first;
	assign q_item.last   = last;
	assign q_item.pt     = pt_q;
	assign q_item.seq    = seq_q;
	assign q_item.ts     = ts_q;
	assign q_item.ssrc   = ssrc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spp_q  <= rtpl16_pkg::SPP_RESET;
			pt_q   <= rtpl16_pkg::PT_RESET;
			ssrc_q <= rtpl16_pkg::SSRC_RESET;
			seq_q  <= '0;
			ts_q   <= '0;
			pos_q  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					rtpl16_pkg::CFG_SPP:  spp_q  <= cfg_data[rtpl16_pkg::SPP_W-1:0];
					rtpl16_pkg::CFG_PT:   pt_q   <= cfg_data[rtpl16_pkg::PT_W-1:0];
					rtpl16_pkg::CFG_SSRC: ssrc_q <= cfg_data[rtpl16_pkg::SSRC_W-1:0];
					default: ;
				endcase
			end
			if (accept) begin
				if (last) begin
					pos_q <= '0;
					seq_q <= seq_q + 1'b1;
					ts_q  <= ts_q + rtpl16_pkg::TS_W'(len);
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

endmodule

@@ src/rtpl16_back.sv @@
// Back end: walks each queued item byte by byte into the output register.
// Depends on rtpl16_pkg for the item layout and byte positions.
module rtpl16_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rtpl16_pkg::q_stat_t  q_stat,
	input  rtpl16_pkg::item_t    q_item,
	output logic                 q_pop,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [7:0]           m_axis_tdata,
	output logic                 m_axis_tlast
);

	logic                               active_q;
	logic [rtpl16_pkg::BYTE_IDX_W-1:0]  idx_q;
	logic                               tvalid_q;
	logic [7:0]                         tdata_q;
	logic                               tlast_q;

	logic [rtpl16_pkg::BYTE_IDX_W-1:0]  idx;
	logic [rtpl16_pkg::BYTE_IDX_W-1:0]  rev;
	logic [rtpl16_pkg::HDR_W-1:0]       hdr_vec;
	logic [7:0]                         byte_sel;
	logic                               load;
	logic                               final_byte;

	// An item without a header starts straight at its sample bytes.
	assign idx = active_q ? idx_q
		: (q_item.hdr ? rtpl16_pkg::BYTE_HDR_FIRST : rtpl16_pkg::BYTE_SAMPLE_HI);
	assign rev = rtpl16_pkg::BYTE_HDR_LAST - idx;
	assign hdr_vec = {rtpl16_pkg::RTP_V2_BYTE, 1'b0, q_item.pt, q_item.seq, q_item.ts,
		q_item.ssrc};

	always_comb begin
		if (idx == rtpl16_pkg::BYTE_SAMPLE_HI) begin
			byte_sel = q_item.sample[15:8];
		end else if (idx == rtpl16_pkg::BYTE_SAMPLE_LO) begin
			byte_sel = q_item.sample[7:0];
		end else begin
			byte_sel = hdr_vec[{rev, 3'b000} +: 8];
		end
	end

	assign load       = !q_stat.empty && (!tvalid_q || m_axis_tready);
	assign final_byte = (idx == rtpl16_pkg::BYTE_SAMPLE_LO);
	assign q_pop      = load && final_byte;

	assign m_axis_tvalid = tvalid_q;
	assign m_axis_tdata  = tdata_q;
	assign m_axis_tlast  = tlast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
			tvalid_q <= 1'b0;
		end else begin
			if (load) begin
				tvalid_q <= 1'b1;
				if (final_byte) begin
					active_q <= 1'b0;
				end else begin
					active_q <= 1'b1;
					idx_q    <= idx + 1'b1;
				end
			end else if (m_axis_tready) begin
				tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tdata_q <= byte_sel;
			tlast_q <= final_byte && q_item.last;
		end
	end

endmodule

@@ src/rtp_l16_audio_packetizer.sv @@
// Top level of the RTP L16 mono packetizer.
// Instantiates rtpl16_front, rtpl16_queue and rtpl16_back; uses rtpl16_pkg.
//
// s_axis carries one 32-bit microphone word per transaction; bits 26 to 11
// become a signed 16-bit sample. m_axis carries the packet one byte per
// transaction, tlast marking the final sample byte of each packet. Every
// sample gives two bytes, high byte first; the first sample of a packet is
// preceded by the 12-byte RTP header (version byte, payload type, sequence
// number, timestamp, SSRC, all big-endian).
// The cfg channel writes samples per packet (index 0), payload type (1) and
// SSRC (2); it is always ready and should only be used while the block is idle.
// A word accepted into an empty block is stored in the queue, and its first byte
// is then loaded into the output register, which issues one byte per cycle while
// the receiver is ready and a word is queued; the header sample gives twelve more
// bytes. The two-entry queue holds the word being serialised and one more.
// Reset clears sequence number, timestamp and position, and loads the
// register defaults (240 samples, type 11, SSRC 0x12345678).
// When the receiver stalls, the current byte holds and the queue fills, after
// which s_axis_tready drops until bytes drain.
module rtp_l16_audio_packetizer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [rtpl16_pkg::WORD_W-1:0]     s_axis_tdata,   // [31:0] mic_word
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [7:0]                        m_axis_tdata,   // [7:0] out_byte
	output logic                              m_axis_tlast,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rtpl16_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rtpl16_pkg::CFG_DATA_W-1:0] cfg_data
);

	rtpl16_pkg::q_req_t  q_req;
	rtpl16_pkg::q_stat_t q_stat;
	rtpl16_pkg::item_t   wr_item;
	rtpl16_pkg::item_t   rd_item;

	rtpl16_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.q_stat        (q_stat),
		.q_push        (q_req.push),
		.q_item        (wr_item)
	);

	rtpl16_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (q_req),
		.wr_item (wr_item),
		.stat    (q_stat),
		.rd_item (rd_item)
	);

	rtpl16_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_stat        (q_stat),
		.q_item        (rd_item),
		.q_pop         (q_req.pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

@@ src/rtpl16_checker.sv @@
// Port-level checker for the RTP L16 packetizer, bound to the top level.
// Depends on rtp_l16_audio_packetizer_macros.svh and rtpl16_pkg.
`include "rtp_l16_audio_packetizer_macros.svh"

module rtpl16_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       m_axis_tlast,
	input logic       cfg_ready
);

	logic out_acc;
	logic expect_start_q;
	logic after_start_q;

	assign out_acc = m_axis_tvalid && m_axis_tready;

	// A packet always opens with the version byte, which is never its last byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_start_q <= 1'b1;
			after_start_q  <= 1'b0;
		end else if (out_acc) begin
			expect_start_q <= m_axis_tlast;
			after_start_q  <= expect_start_q;
		end
	end

	`RTPL16_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output changed while stalled")
	`RTPL16_ASSERT_SAME(a_start_byte, clk, arst_n, out_acc && expect_start_q, m_axis_tdata == rtpl16_pkg::RTP_V2_BYTE && !m_axis_tlast, "packet does not open with the version byte")
	`RTPL16_ASSERT_SAME(a_pt_byte, clk, arst_n, out_acc && after_start_q, !m_axis_tdata[7] && !m_axis_tlast, "payload type byte has its top bit set")
	`RTPL16_ASSERT_SAME(a_cfg_ready, clk, arst_n, 1'b1, cfg_ready, "configuration channel not ready")

endmodule

bind rtp_l16_audio_packetizer rtpl16_checker u_rtpl16_checker (.*);

@@ bench/tb_rtp_l16_audio_packetizer.sv @@
// Self-checking testbench for the RTP L16 mono packetizer: directed and random
// microphone words, with byte-level checking against a built-in packet model.
// Depends on rtpl16_pkg and the rtp_l16_audio_packetizer top level.
module tb_rtp_l16_audio_packetizer;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [rtpl16_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 20;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} rtp_byte_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              s_axis_tvalid = 1'b0;
	logic                              s_axis_tready;
	logic [rtpl16_pkg::WORD_W-1:0]     s_axis_tdata = '0;
	logic                              m_axis_tvalid;
	logic                              m_axis_tready = 1'b0;
	logic [7:0]                        m_axis_tdata;
	logic                              m_axis_tlast;
	logic                              cfg_valid = 1'b0;
	logic                              cfg_ready;
	logic [rtpl16_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [rtpl16_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// Packet model: registers and running state.
	logic [rtpl16_pkg::SPP_W-1:0]  pk_len_reg;
	logic [rtpl16_pkg::PT_W-1:0]   pk_type;
	logic [rtpl16_pkg::SSRC_W-1:0] pk_ssrc;
	logic [rtpl16_pkg::SEQ_W-1:0]  pk_seq;
	logic [rtpl16_pkg::TS_W-1:0]   pk_stamp;
	logic [rtpl16_pkg::SPP_W-1:0]  pk_pos;

	rtp_byte_t pending_bytes[$];
	rtp_byte_t head_byte;

	int mismatches = 0;
	int cycle_count = 0;
	int send_gap_pct = 0;
	int recv_stall_pct = 0;
	int hold_left = 0;

	rtp_l16_audio_packetizer DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),   // [31:0] mic_word
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),   // [7:0] out_byte
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_rtp_l16_audio_packetizer NOT OK");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t ns: %s mismatch, got %0h, want %0h", $time, what, got, want);
		mismatches++;
	endtask

	// A long receiver hold-off is counted down here once the stimulus asks for one.
	always @(posedge clk) begin
		if (hold_left > 0)
			hold_left--;
	end

	// Receiver: checks each byte transaction and decides tready for the next edge.
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_bytes.size() == 0) begin
				report_mismatch("unexpected byte", 32'(m_axis_tdata), 32'd0);
			end else begin
				head_byte = pending_bytes.pop_front();
				if (m_axis_tdata !== head_byte.data)
					report_mismatch("out_byte", 32'(m_axis_tdata), 32'(head_byte.data));
				if (m_axis_tlast !== head_byte.last)
					report_mismatch("packet_end", 32'(m_axis_tlast), 32'(head_byte.last));
			end
		end
		m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic model_reset();
		pk_len_reg = rtpl16_pkg::SPP_RESET;
		pk_type    = rtpl16_pkg::PT_RESET;
		pk_ssrc    = rtpl16_pkg::SSRC_RESET;
		pk_seq     = '0;
		pk_stamp   = '0;
		pk_pos     = '0;
	endtask

	// Works out the bytes one accepted microphone word produces.
	task automatic packetize_word(input logic [rtpl16_pkg::WORD_W-1:0] word);
		logic [rtpl16_pkg::SAMPLE_W-1:0] smp;
		logic [rtpl16_pkg::SPP_W:0]      len;
		logic [rtpl16_pkg::HDR_W-1:0]    hdr;
		logic                            ends;
		smp = word[rtpl16_pkg::SAMPLE_MSB:rtpl16_pkg::SAMPLE_LSB];
		len = (pk_len_reg == '0) ? (rtpl16_pkg::SPP_W+1)'(1) : {1'b0, pk_len_reg};
		if (pk_pos == '0) begin
			hdr = {rtpl16_pkg::RTP_V2_BYTE, 1'b0, pk_type, pk_seq, pk_stamp, pk_ssrc};
			for (int i = rtpl16_pkg::HDR_W / 8 - 1; i >= 0; i--)
				pending_bytes.push_back('{data: hdr[i*8 +: 8], last: 1'b0});
		end
		ends = ({1'b0, pk_pos} + 1'b1) >= len;
		pending_bytes.push_back('{data: smp[15:8], last: 1'b0});
		pending_bytes.push_back('{data: smp[7:0], last: ends});
		if (ends) begin
			pk_pos   = '0;
			pk_seq   = pk_seq + 1'b1;
			pk_stamp = pk_stamp + rtpl16_pkg::TS_W'(len);
		end else begin
			pk_pos = pk_pos + 1'b1;
		end
	endtask

	// Offers one word, with random idle cycles first, and predicts on acceptance.
	task automatic send_word(input logic [rtpl16_pkg::WORD_W-1:0] word);
		while ($urandom_range(99) < send_gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= word;
		do @(posedge clk); while (!s_axis_tready);
		packetize_word(word);
	endtask

	// Leaves cfg_valid high so that back-to-back writes need no second assignment.
	task automatic cfg_write(input logic [rtpl16_pkg::CFG_IDX_W-1:0] idx,
			input logic [rtpl16_pkg::CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			rtpl16_pkg::CFG_SPP:  pk_len_reg = val[rtpl16_pkg::SPP_W-1:0];
			rtpl16_pkg::CFG_PT:   pk_type = val[rtpl16_pkg::PT_W-1:0];
			rtpl16_pkg::CFG_SSRC: pk_ssrc = val;
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [rtpl16_pkg::CFG_DATA_W-1:0] spp_val,
			input logic [rtpl16_pkg::CFG_DATA_W-1:0] pt_val,
			input logic [rtpl16_pkg::CFG_DATA_W-1:0] ssrc_val);
		cfg_write(rtpl16_pkg::CFG_SPP, spp_val);
		cfg_write(rtpl16_pkg::CFG_PT, pt_val);
		cfg_write(rtpl16_pkg::CFG_SSRC, ssrc_val);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (pending_bytes.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [rtpl16_pkg::WORD_W-1:0] edge_word(input int sel);
		case (sel)
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			4: return 32'h0400_0000;   // most negative sample
			5: return 32'h03FF_F800;   // most positive sample
			6: return 32'hF800_07FF;   // zero sample, all other bits set
			default: return 32'h0000_0800;
		endcase
	endfunction

	task automatic test_reset_defaults();
		send_word(edge_word(0));
		send_word(edge_word(1));
		send_word(edge_word(2));
		wait_idle();
	endtask

	// One sample per packet, so every word carries a header with the widest fields.
	task automatic test_sample_extremes();
		set_config(32'd1, 32'd127, 32'hFFFF_FFFF);
		for (int i = 0; i < 8; i++)
			send_word(edge_word(i));
		wait_idle();
	endtask

	// A zero length behaves as one; the upper data bits must be ignored.
	task automatic test_zero_length();
		set_config(32'hFFFF_FC00, 32'hFFFF_FF80, 32'h0000_0000);
		send_word(edge_word(3));
		send_word(edge_word(4));
		send_word(edge_word(5));
		wait_idle();
	endtask

	task automatic test_unused_index();
		cfg_write(CFG_UNUSED, $urandom);
		cfg_valid <= 1'b0;
		send_word($urandom);
		send_word($urandom);
		wait_idle();
	endtask

	// Lowering the length below the current position ends the packet on the next sample.
	task automatic test_length_change();
		set_config(32'd1023, 32'd96, 32'hA5A5_5A5A);
		for (int i = 0; i < 4; i++)
			send_word($urandom);
		wait_idle();
		cfg_write(rtpl16_pkg::CFG_SPP, 32'd2);
		cfg_valid <= 1'b0;
		send_word($urandom);
		wait_idle();
		cfg_write(rtpl16_pkg::CFG_SPP, 32'd8);
		cfg_valid <= 1'b0;
		for (int i = 0; i < 4; i++)
			send_word($urandom);
		wait_idle();
		cfg_write(rtpl16_pkg::CFG_SPP, 32'd3);
		cfg_valid <= 1'b0;
		send_word($urandom);
		wait_idle();
	endtask

	// The receiver stops for a long stretch while words keep coming.
	task automatic test_backpressure();
		send_gap_pct = 0;
		recv_stall_pct = 0;
		set_config(32'd5, $urandom, $urandom);
		hold_left = 400;
		for (int i = 0; i < 24; i++)
			send_word($urandom);
		wait_idle();
	endtask

	task automatic test_random_traffic(input int gap_pct, input int stall_pct, input int n_words);
		logic [rtpl16_pkg::SPP_W-1:0] spp_pick;
		send_gap_pct = gap_pct;
		recv_stall_pct = stall_pct;
		case ($urandom_range(9))
			0: spp_pick = rtpl16_pkg::SPP_W'(1);
			1: spp_pick = rtpl16_pkg::SPP_W'($urandom_range(20, 40));
			default: spp_pick = rtpl16_pkg::SPP_W'($urandom_range(2, 8));
		endcase
		set_config(($urandom & ~32'h3FF) | 32'(spp_pick), $urandom, $urandom);
		for (int i = 0; i < n_words; i++) begin
			if ($urandom_range(7) == 0)
				send_word(edge_word($urandom_range(7)));
			else
				send_word($urandom);
		end
		wait_idle();
	endtask

	initial begin
		model_reset();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_sample_extremes();
		test_zero_length();
		test_unused_index();
		test_length_change();
		test_random_traffic(0, 0, 60);
		test_random_traffic(81, 0, 50);
		test_random_traffic(0, 81, 50);
		test_random_traffic(6, 6, 60);
		test_backpressure();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_bytes.size() == 0) begin
			$display("tb_rtp_l16_audio_packetizer OK");
		end else begin
			$display("tb_rtp_l16_audio_packetizer NOT OK");
		end
		$finish;
	end

endmodule
